[hdl/rlm_pkg.sv]
`timescale 1ns / 1ps

package rlm_pkg;

    // Field widths
    localparam int LEN_W  = 10;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;
    localparam int ST_W   = 3;

    // Default ring size and register reset value
    localparam int              RING_BYTES_DEF = 1024;
    localparam logic [LEN_W-1:0] MAX_LEN_RST   = 10'd1021;
    localparam logic [1:0]       HDR_BYTES     = 2'd2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_CORRUPT  = 3'd3;
    localparam logic [ST_W-1:0] ST_TOO_LONG = 3'd4;
    localparam logic [ST_W-1:0] ST_OOS      = 3'd5;

    // One result beat
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BYTE_W-1:0] rd_byte;
        logic              last;
    } t_result;

endpackage

[hdl/rlm_core.sv]
`timescale 1ns / 1ps

module rlm_core import rlm_pkg::*; #(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [LEN_W-1:0]  i_message_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_max_read_len,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    localparam int PW = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
    localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int HW = 2 * BYTE_W;
    localparam int UW = ((PW > HW) ? PW : HW) + 1;
    localparam logic [PW:0] RING_N = (PW + 1)'(RING_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR0 = 3'd1;
    localparam logic [2:0] S_HDR1 = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Pointer increment modulo ring size (n is at most 2)
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] n);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(n);
        if (s >= RING_N) begin
            s = s - RING_N;
        end
        return s[PW-1:0];
    endfunction

    logic [2:0]        r_state, n_state;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_pwp, n_pwp;
    logic [PW-1:0]     r_haddr, n_haddr;
    logic [LEN_W-1:0]  r_wleft, n_wleft;
    logic [LEN_W-1:0]  r_rleft, n_rleft;
    logic              r_writing, n_writing;
    logic              r_reading, n_reading;
    logic [BYTE_W-1:0] r_hlo, n_hlo;
    logic [BYTE_W-1:0] r_hhi, n_hhi;
    t_result           r_pend, n_pend;

    // Byte store, single port, registered read
    logic [BYTE_W-1:0] r_mem [RING_BYTES];
    logic [BYTE_W-1:0] r_rdata;
    logic              mem_we;
    logic              mem_re;
    logic [PW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // Occupancy and free-space check
    logic [PW:0]     used_ext;
    logic [PW-1:0]   used;
    logic [PW:0]     free_b;
    logic            no_room;
    logic [HW-1:0]   hlen;
    logic            fin;
    t_result         res;

    assign used_ext = {1'b0, r_wp} + ((r_wp >= r_rp) ? '0 : RING_N) - {1'b0, r_rp};
    assign used     = used_ext[PW-1:0];
    assign free_b   = RING_N - (PW + 1)'(1) - {1'b0, used};
    assign no_room  = CW'(free_b) < (CW'(i_message_length) + CW'(HDR_BYTES));
    assign hlen     = {r_rdata, r_hlo};

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = fin || (r_state == S_DONE);
    assign o_res       = (r_state == S_DONE) ? r_pend : res;

    // Sequencer: one item at a time, memory read-modify around pointers
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_pwp     = r_pwp;
        n_haddr   = r_haddr;
        n_wleft   = r_wleft;
        n_rleft   = r_rleft;
        n_writing = r_writing;
        n_reading = r_reading;
        n_hlo     = r_hlo;
        n_hhi     = r_hhi;
        n_pend    = r_pend;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_rp;
        mem_wdata = i_data_byte;
        fin       = 1'b0;
        res       = '{status: ST_OK, rd_byte: '0, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_operation)
                        OP_START: begin
                            if (r_writing) begin
                                res.status = ST_OOS;
                                fin        = 1'b1;
                            end else if (no_room) begin
                                res.status = ST_FULL;
                                fin        = 1'b1;
                            end else begin
                                // low header byte now, high byte next cycle
                                mem_we    = 1'b1;
                                mem_addr  = r_wp;
                                mem_wdata = i_message_length[BYTE_W-1:0];
                                n_hhi     = BYTE_W'(i_message_length >> BYTE_W);
                                n_haddr   = wrap_add(r_wp, 2'd1);
                                n_pwp     = wrap_add(r_wp, HDR_BYTES);
                                n_wleft   = i_message_length;
                                if (i_message_length == '0) begin
                                    n_wp = wrap_add(r_wp, HDR_BYTES);
                                end else begin
                                    n_writing = 1'b1;
                                end
                                n_state = S_WR2;
                            end
                        end
                        OP_WRITE: begin
                            fin = 1'b1;
                            if (!r_writing) begin
                                res.status = ST_OOS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_addr  = r_pwp;
                                mem_wdata = i_data_byte;
                                n_pwp     = wrap_add(r_pwp, 2'd1);
                                n_wleft   = r_wleft - LEN_W'(1);
                                if (n_wleft == '0) begin
                                    // commit the whole message
                                    n_wp      = n_pwp;
                                    n_writing = 1'b0;
                                    res.last  = 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            if (r_reading) begin
                                mem_re   = 1'b1;
                                mem_addr = r_rp;
                                n_state  = S_RD;
                            end else if (used == '0) begin
                                res.status = ST_EMPTY;
                                fin        = 1'b1;
                            end else if (used <= PW'(HDR_BYTES)) begin
                                res.status = ST_CORRUPT;
                                fin        = 1'b1;
                            end else begin
                                mem_re   = 1'b1;
                                mem_addr = r_rp;
                                n_state  = S_HDR0;
                            end
                        end
                        default: begin
                            res.status = ST_OOS;
                            fin        = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR0: begin
                n_hlo    = r_rdata;
                mem_re   = 1'b1;
                mem_addr = wrap_add(r_rp, 2'd1);
                n_state  = S_HDR1;
            end
            S_HDR1: begin
                // header checks, in priority order
                if (hlen > HW'(i_max_read_len)) begin
                    res.status = ST_TOO_LONG;
                    fin        = 1'b1;
                end else if (UW'(hlen) > (UW'(used) - UW'(HDR_BYTES))) begin
                    res.status = ST_CORRUPT;
                    fin        = 1'b1;
                end else begin
                    n_rp = wrap_add(r_rp, HDR_BYTES);
                    if (hlen == '0) begin
                        res.last = 1'b1;
                        fin      = 1'b1;
                    end else begin
                        n_rleft   = hlen[LEN_W-1:0];
                        n_reading = 1'b1;
                        mem_re    = 1'b1;
                        mem_addr  = wrap_add(r_rp, HDR_BYTES);
                        n_state   = S_RD;
                    end
                end
            end
            S_RD: begin
                n_rp        = wrap_add(r_rp, 2'd1);
                n_rleft     = r_rleft - LEN_W'(1);
                res.rd_byte = r_rdata;
                if (n_rleft == '0) begin
                    res.last  = 1'b1;
                    n_reading = 1'b0;
                end
                fin = 1'b1;
            end
            S_WR2: begin
                mem_we    = 1'b1;
                mem_addr  = r_haddr;
                mem_wdata = r_hhi;
                res.last  = (r_wleft == '0);
                fin       = 1'b1;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // park the result when the output slot is busy
        if (fin) begin
            if (i_res_ready) begin
                n_state = S_IDLE;
            end else begin
                n_pend  = res;
                n_state = S_DONE;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_pwp     <= '0;
            r_wleft   <= '0;
            r_rleft   <= '0;
            r_writing <= 1'b0;
            r_reading <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_pwp     <= n_pwp;
            r_wleft   <= n_wleft;
            r_rleft   <= n_rleft;
            r_writing <= n_writing;
            r_reading <= n_reading;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_haddr <= n_haddr;
        r_hlo   <= n_hlo;
        r_hhi   <= n_hhi;
        r_pend  <= n_pend;
    end

endmodule

[hdl/rlm_out_reg.sv]
`timescale 1ns / 1ps

module rlm_out_reg import rlm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_ready,
    input  t_result           i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_last_of_message
);

    logic    r_valid;
    t_result r_res;

    // slot frees when empty or being taken this cycle
    assign o_res_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_res.status;
    assign o_read_byte       = r_res.rd_byte;
    assign o_last_of_message = r_res.last;

endmodule

[hdl/length_prefixed_message_ring.sv]
`timescale 1ns / 1ps
// Length-prefixed message ring: a byte store of RING_BYTES entries holding
// messages, each led by a two-byte little-endian length header.
// Input channel (i_in_valid / o_in_ready) carries one operation per beat:
// start_write with a length, write_byte with a data byte, or read_byte.
// Output channel (o_out_valid / i_out_ready) returns exactly one result beat
// per input beat: status, read byte and last-of-message mark.
// i_cfg_we / i_cfg_data write max_read_len at once; write it only when idle.
// Path from accept to result on the output register, one item at a time:
//   write_byte and errors found without a header read: result formed in the idle state
//   start_write: two header writes on the single memory port
//   read_byte inside a message: one registered memory read
//   read_byte at a message start: two header reads, then payload
//   header error or empty message at a message start: two header reads
// A new item is taken as soon as the previous one has left the sequencer,
// even while its result still waits in the output register.
// If the receiver stalls, a finished result is parked and the sequencer
// holds until the output register frees.
// Reset (synchronous, active low) empties the ring and closes any open
// read or write; store contents are not cleared and need no clearing pass.
module length_prefixed_message_ring import rlm_pkg::*; #(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [LEN_W-1:0]  i_message_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_last_of_message,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    logic [LEN_W-1:0] r_max_read_len;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_read_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_read_len <= i_cfg_data;
        end
    end

    rlm_core #(
        .RING_BYTES (RING_BYTES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_operation      (i_operation),
        .i_message_length (i_message_length),
        .i_data_byte      (i_data_byte),
        .i_max_read_len   (r_max_read_len),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res)
    );

    rlm_out_reg u_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_res_valid       (res_valid),
        .o_res_ready       (res_ready),
        .i_res             (res),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_status          (o_status),
        .o_read_byte       (o_read_byte),
        .o_last_of_message (o_last_of_message)
    );

endmodule
